FILE: sv/phm_pkg.sv
// Shared types and constants for the pedestal hit multiplicity block.
// No dependencies; every other file refers to it by scoped names.
package phm_pkg;

  localparam int ModeW      = 2;
  localparam int DetW       = 2;
  localparam int ChanW      = 4;
  localparam int EnergyW    = 14;
  localparam int MeanW      = 18;
  localparam int SigmaW     = 16;
  localparam int BinW       = 5;
  localparam int CountW     = 32;
  localparam int SigMultW   = 4;
  localparam int ThreshW    = 21;   // mean + sigma * 15 never exceeds 21 bits

  localparam int HistBins   = 17;
  localparam logic [BinW-1:0]   HitsMax  = 5'd31;
  localparam logic [CountW-1:0] CountMax = 32'hFFFF_FFFF;

  localparam int FifoDepth  = 4;

  // configuration port
  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = 32;
  localparam logic [0:0] REG_SIGMA_MULT = 1'b0;
  localparam logic [SigMultW-1:0] SigmaMultReset = 4'd5;

  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // histogram operation handed from the threshold stage to the histogram stage
  typedef enum logic [1:0] {
    HOP_NULL  = 2'd0,   // result with count zero, no memory access
    HOP_READ  = 2'd1,
    HOP_INCR  = 2'd2,
    HOP_CLEAR = 2'd3
  } hop_t;

  typedef struct packed {
    logic            valid;
    hop_t            op;
    logic            kind;
    logic [DetW-1:0] det;
    logic [BinW-1:0] mult;
  } hreq_t;

  typedef struct packed {
    logic              kind;
    logic [DetW-1:0]   det;
    logic [BinW-1:0]   mult;
    logic [CountW-1:0] count;
  } result_t;

  typedef struct packed {
    logic [MeanW-1:0]  mean;
    logic [SigmaW-1:0] sigma;
  } ped_entry_t;

endpackage

FILE: sv/phm_in_if.sv
// Input channel of the pedestal hit multiplicity block: valid/ready plus item.
// Depends on phm_pkg for field widths.
interface phm_in_if;
  logic                            valid;
  logic                            ready;
  logic [phm_pkg::ModeW-1:0]       mode;
  logic [phm_pkg::DetW-1:0]        detector;
  logic [phm_pkg::ChanW-1:0]       channel;
  logic [phm_pkg::EnergyW-1:0]     energy;
  logic [phm_pkg::MeanW-1:0]       pedestal_mean;
  logic [phm_pkg::SigmaW-1:0]      pedestal_sigma;
  logic [phm_pkg::BinW-1:0]        bin;

  modport source (output valid, mode, detector, channel, energy, pedestal_mean,
                  pedestal_sigma, bin, input ready);
  modport sink   (input valid, mode, detector, channel, energy, pedestal_mean,
                  pedestal_sigma, bin, output ready);
endinterface

FILE: sv/phm_out_if.sv
// Result channel of the pedestal hit multiplicity block: valid/ready plus result.
// Depends on phm_pkg for field widths.
interface phm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [phm_pkg::DetW-1:0]     out_detector;
  logic [phm_pkg::BinW-1:0]     multiplicity;
  logic [phm_pkg::CountW-1:0]   bin_count;

  modport source (output valid, kind, out_detector, multiplicity, bin_count,
                  input ready);
  modport sink   (input valid, kind, out_detector, multiplicity, bin_count,
                  output ready);
endinterface

FILE: sv/phm_pedestal.sv
// Pedestal store (mean and sigma per channel) and the threshold compare.
// Depends on phm_pkg.
module phm_pedestal #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     addr,
  input  phm_pkg::ped_entry_t               wr_data,
  input  logic [phm_pkg::EnergyW-1:0]       energy,     // item now in the compare stage
  input  logic [phm_pkg::SigMultW-1:0]      sig_mult,
  output logic                              hit
);

  phm_pkg::ped_entry_t mem [DEPTH];
  phm_pkg::ped_entry_t rd_r;

  logic [phm_pkg::ThreshW-1:0] thresh;
  logic [phm_pkg::ThreshW-1:0] lhs;

  // single port: a transfer is either a load or a sample
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end else if (rd_en) begin
      rd_r <= mem[addr];
    end
  end

  // energy * 16 against mean + sigma * k, exact
  always_comb begin
    thresh = phm_pkg::ThreshW'(rd_r.mean)
           + phm_pkg::ThreshW'(rd_r.sigma * phm_pkg::ThreshW'(sig_mult));
    lhs    = phm_pkg::ThreshW'({energy, 4'b0000});
    hit    = lhs > thresh;
  end

endmodule

FILE: sv/phm_hist.sv
// Histogram store: read-modify-write of saturating bin counts, per-entry valid
// bits for reset and clear, one-deep write forwarding. Depends on phm_pkg.
module phm_hist #(
  parameter int DEPTH = 68,
  parameter int AW    = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  phm_pkg::hreq_t    req,
  input  logic [AW-1:0]     req_addr,
  output phm_pkg::result_t  res,
  output logic              res_valid,
  output logic              busy
);

  logic [phm_pkg::CountW-1:0] mem [DEPTH];
  logic [phm_pkg::CountW-1:0] rd_r;
  logic [DEPTH-1:0]           hv_r;

  phm_pkg::hreq_t             s2_req_r;
  logic [AW-1:0]              s2_addr_r;

  logic                       fw_v_r;
  logic [AW-1:0]              fw_addr_r;
  logic [phm_pkg::CountW-1:0] fw_data_r;

  logic                       rd_en;
  logic                       wr_en;
  logic                       clr;
  logic [phm_pkg::CountW-1:0] cur;
  logic [phm_pkg::CountW-1:0] inc;

  assign rd_en = req.valid && (req.op == phm_pkg::HOP_READ || req.op == phm_pkg::HOP_INCR);
  assign wr_en = s2_req_r.valid && s2_req_r.op == phm_pkg::HOP_INCR;
  assign clr   = s2_req_r.valid && s2_req_r.op == phm_pkg::HOP_CLEAR;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[req_addr];
    end
    if (wr_en) begin
      mem[s2_addr_r] <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_req_r <= '0;
      hv_r     <= '0;
      fw_v_r   <= 1'b0;
    end else begin
      s2_req_r <= req;
      fw_v_r   <= wr_en;
      if (clr) begin
        hv_r <= '0;
      end else if (wr_en) begin
        hv_r[s2_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_addr_r <= req_addr;
    fw_addr_r <= s2_addr_r;
    fw_data_r <= inc;
  end

  // the previous write lands at the same edge as this item's read
  always_comb begin
    if (fw_v_r && fw_addr_r == s2_addr_r) begin
      cur = fw_data_r;
    end else if (hv_r[s2_addr_r]) begin
      cur = rd_r;
    end else begin
      cur = '0;
    end
    inc = (cur == phm_pkg::CountMax) ? cur : cur + 32'd1;
  end

  always_comb begin
    res.kind = s2_req_r.kind;
    res.det  = s2_req_r.det;
    res.mult = s2_req_r.mult;
    case (s2_req_r.op)
      phm_pkg::HOP_READ: res.count = cur;
      phm_pkg::HOP_INCR: res.count = inc;
      default:           res.count = '0;
    endcase
  end

  assign res_valid = s2_req_r.valid && s2_req_r.op != phm_pkg::HOP_CLEAR;
  assign busy      = s2_req_r.valid;

endmodule

FILE: sv/phm_out_fifo.sv
// Small result queue that drives the result channel.
// Depends on phm_pkg and phm_out_if.
module phm_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  phm_pkg::result_t      push_data,
  output logic [$clog2(phm_pkg::FifoDepth+1)-1:0] count,
  phm_out_if.source             out_ch
);

  localparam int PW = $clog2(phm_pkg::FifoDepth);
  localparam int CW = $clog2(phm_pkg::FifoDepth + 1);

  phm_pkg::result_t q_r [phm_pkg::FifoDepth];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             pop;
  phm_pkg::result_t head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  assign count               = cnt_r;
  assign out_ch.valid        = cnt_r != '0;
  assign out_ch.kind         = head.kind;
  assign out_ch.out_detector = head.det;
  assign out_ch.multiplicity = head.mult;
  assign out_ch.bin_count    = head.count;

endmodule

FILE: sv/pedestal_hit_multiplicity.sv
// Pedestal hit multiplicity: top level with decode, threshold stage, hit
// counters and configuration register. Depends on phm_pkg, phm_in_if,
// phm_out_if, phm_pedestal, phm_hist and phm_out_fifo.
//
// Usage: in_ch carries one item per transfer: pedestal load, energy sample,
// histogram bin read or histogram clear. Samples on channel CHANNELS-1 close
// the detector's event and produce a multiplicity result on out_ch; reads
// produce a bin result. Loads, clears and other samples produce nothing.
// Stages: pedestal read and compare, then histogram read-modify-write into
// the result queue that drives out_ch. Throughput: one item per cycle while
// in_ch.ready is high; the histogram memory port does one read and one write
// per cycle, with the newest write forwarded to the next item. A four-entry
// result queue with credit counting: items in the two stages and queued
// results each hold a credit. At full rate three are in use, so a stall of
// out_ch with a result queued drops in_ch.ready until it drains.
// Reset (rst_n low, synchronous) empties the pipeline and queue, zeroes the
// hit counters and all histogram bins (per-bin valid bits) and sets
// sigma_multiplier to 5. Pedestals are not reset; load them before sampling.
// cfg_* is an APB write/read port; sigma_multiplier sits at address 0.
module pedestal_hit_multiplicity #(
  parameter int DETECTORS = 4,
  parameter int CHANNELS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  phm_in_if.sink                         in_ch,
  phm_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [phm_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [phm_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [phm_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);

  localparam int PedDepth  = DETECTORS * CHANNELS;
  localparam int PedAw     = $clog2(PedDepth);
  localparam int HistDepth = DETECTORS * phm_pkg::HistBins;
  localparam int HistAw    = $clog2(HistDepth);
  localparam int DetIw     = (DETECTORS > 1) ? $clog2(DETECTORS) : 1;
  localparam int CreditW   = $clog2(phm_pkg::FifoDepth + 1) + 1;

  // ---------------- configuration ----------------
  logic [phm_pkg::SigMultW-1:0] sig_mult_r;
  logic                         cfg_wr;
  logic [0:0]                   cfg_idx;

  assign cfg_idx    = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_mult_r <= phm_pkg::SigmaMultReset;
    end else if (cfg_wr && cfg_idx == phm_pkg::REG_SIGMA_MULT) begin
      sig_mult_r <= cfg_pwdata[phm_pkg::SigMultW-1:0];
    end
  end

  always_comb begin
    if (cfg_idx == phm_pkg::REG_SIGMA_MULT) begin
      cfg_prdata = phm_pkg::CfgDataW'(sig_mult_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // ---------------- input decode ----------------
  logic           acc;
  phm_pkg::mode_t in_mode;
  logic           det_ok, ch_ok;
  logic [PedAw-1:0] ped_addr;

  assign acc     = in_ch.valid && in_ch.ready;
  assign in_mode = phm_pkg::mode_t'(in_ch.mode);
  assign det_ok  = 32'(in_ch.detector) < 32'(DETECTORS);
  assign ch_ok   = 32'(in_ch.channel) < 32'(CHANNELS);
  assign ped_addr = PedAw'(PedAw'(in_ch.detector) * PedAw'(CHANNELS))
                  + PedAw'(in_ch.channel);

  phm_pkg::ped_entry_t ped_wr;
  logic                hit;

  assign ped_wr.mean  = in_ch.pedestal_mean;
  assign ped_wr.sigma = in_ch.pedestal_sigma;

  // ---------------- compare stage registers ----------------
  logic                            s1_v_r;
  phm_pkg::mode_t                  s1_mode_r;
  logic                            s1_ok_r;    // indices in range for the mode
  logic [phm_pkg::DetW-1:0]        s1_det_r;
  logic [phm_pkg::ChanW-1:0]       s1_ch_r;
  logic [phm_pkg::EnergyW-1:0]     s1_energy_r;
  logic [phm_pkg::BinW-1:0]        s1_bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc && in_mode != phm_pkg::MODE_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    s1_mode_r   <= in_mode;
    s1_ok_r     <= (in_mode == phm_pkg::MODE_READ) ? det_ok : (det_ok && ch_ok);
    s1_det_r    <= in_ch.detector;
    s1_ch_r     <= in_ch.channel;
    s1_energy_r <= in_ch.energy;
    s1_bin_r    <= in_ch.bin;
  end

  phm_pedestal #(
    .DEPTH (PedDepth),
    .AW    (PedAw)
  ) u_ped (
    .clk      (clk),
    .wr_en    (acc && in_mode == phm_pkg::MODE_LOAD && det_ok && ch_ok),
    .rd_en    (acc && in_mode == phm_pkg::MODE_SAMPLE && det_ok && ch_ok),
    .addr     (ped_addr),
    .wr_data  (ped_wr),
    .energy   (s1_energy_r),
    .sig_mult (sig_mult_r),
    .hit      (hit)
  );

  // ---------------- per-detector hit counters ----------------
  logic [phm_pkg::BinW-1:0] run_hits_r   [DETECTORS];
  logic [phm_pkg::BinW-1:0] run_hits_nxt [DETECTORS];
  logic [DetIw-1:0]         s1_det_idx;
  logic [phm_pkg::BinW-1:0] hits_cur, hits_new;
  logic                     last_ch;
  logic [phm_pkg::BinW-1:0] hist_bin;

  phm_pkg::hreq_t           hreq;
  logic [HistAw-1:0]        hreq_addr;

  assign s1_det_idx = DetIw'(s1_det_r);
  assign hits_cur   = run_hits_r[s1_det_idx];
  assign hits_new   = hits_cur + phm_pkg::BinW'(hit && hits_cur != phm_pkg::HitsMax);
  assign last_ch    = 32'(s1_ch_r) == 32'(CHANNELS - 1);
  assign hist_bin   = (s1_mode_r == phm_pkg::MODE_READ) ? s1_bin_r : hits_new;
  assign hreq_addr  = HistAw'(HistAw'(s1_det_r) * HistAw'(phm_pkg::HistBins))
                    + HistAw'(hist_bin);

  always_comb begin
    run_hits_nxt = run_hits_r;
    hreq.valid   = 1'b0;
    hreq.op      = phm_pkg::HOP_NULL;
    hreq.kind    = phm_pkg::KIND_EVENT;
    hreq.det     = s1_det_r;
    hreq.mult    = hist_bin;
    if (s1_v_r) begin
      case (s1_mode_r)
        phm_pkg::MODE_SAMPLE: begin
          if (s1_ok_r) begin
            if (last_ch) begin
              // event closes: emit multiplicity, count it if it has a bin
              run_hits_nxt[s1_det_idx] = '0;
              hreq.valid = 1'b1;
              hreq.op    = (32'(hits_new) < 32'(phm_pkg::HistBins)) ?
                           phm_pkg::HOP_INCR : phm_pkg::HOP_NULL;
            end else begin
              run_hits_nxt[s1_det_idx] = hits_new;
            end
          end
        end
        phm_pkg::MODE_READ: begin
          hreq.valid = 1'b1;
          hreq.kind  = phm_pkg::KIND_BIN;
          hreq.op    = (s1_ok_r && 32'(s1_bin_r) < 32'(phm_pkg::HistBins)) ?
                       phm_pkg::HOP_READ : phm_pkg::HOP_NULL;
        end
        phm_pkg::MODE_CLEAR: begin
          hreq.valid = 1'b1;
          hreq.op    = phm_pkg::HOP_CLEAR;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DETECTORS; i++) begin
        run_hits_r[i] <= '0;
      end
    end else begin
      run_hits_r <= run_hits_nxt;
    end
  end

  // ---------------- histogram stage ----------------
  phm_pkg::result_t hres;
  logic             hres_valid;
  logic             s2_busy;

  phm_hist #(
    .DEPTH (HistDepth),
    .AW    (HistAw)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (hreq),
    .req_addr  (hreq_addr),
    .res       (hres),
    .res_valid (hres_valid),
    .busy      (s2_busy)
  );

  // ---------------- result queue and credit ----------------
  logic [$clog2(phm_pkg::FifoDepth+1)-1:0] fifo_cnt;
  logic [CreditW-1:0]                      credit_used;

  phm_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (hres_valid),
    .push_data (hres),
    .count     (fifo_cnt),
    .out_ch    (out_ch)
  );

  // every item still in flight may need a queue slot
  assign credit_used = CreditW'(fifo_cnt) + CreditW'(s1_v_r) + CreditW'(s2_busy);
  assign in_ch.ready = credit_used < CreditW'(phm_pkg::FifoDepth);

endmodule
